FILE: rtl/lprx_pkg.sv
package lprx_pkg;

  localparam int BufferBytesDefault = 8192;
  localparam int DescriptorDepthDefault = 32;

  localparam int HeaderBytes = 2;
  localparam int RawLengthWidth = 16;

  localparam int CommandWidth = 3;
  localparam int ReserveWidth = 14;
  localparam int AddressWidth = 13;
  localparam int DataWidth = 8;
  localparam int StatusWidth = 2;
  localparam int IndexWidth = 13;
  localparam int LengthWidth = 13;

  localparam logic [CommandWidth-1:0] CMD_RESERVE = 3'd0;
  localparam logic [CommandWidth-1:0] CMD_WRITE = 3'd1;
  localparam logic [CommandWidth-1:0] CMD_PROCESS = 3'd2;
  localparam logic [CommandWidth-1:0] CMD_POP = 3'd3;
  localparam logic [CommandWidth-1:0] CMD_READ = 3'd4;

  localparam logic [StatusWidth-1:0] ST_OK = 2'd0;
  localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [StatusWidth-1:0] ST_QFULL = 2'd3;

endpackage

FILE: rtl/lprx_ram.sv
module lprx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/length_prefixed_rx_frame_buffer_core.sv
// Receive buffer for length-prefixed frames. One command enters on the item channel
// (item_valid / item_stall) and gives exactly one result on the result channel
// (result_valid / result_stall). Commands: reserve, write byte, process, pop, read byte.
// The block works on one command at a time; item_stall is high from acceptance until
// the command has been finished and handed to the result register.
// Unknown commands go straight to the result register. A reserve may first move the
// unparsed chunk to the start of the byte store, one byte at a time. Process parses
// frames one after another and reads the two-byte length header of each from the
// byte store, whose single read port is registered.
// The result register holds a finished result while result_stall is high; the next
// command may be accepted meanwhile, and its result waits until the register is free.
// A synchronous reset empties the descriptor queue and the reserved region and drops
// any pending result. The memories are not cleared; a byte read before it was written
// returns an unspecified value.
module length_prefixed_rx_frame_buffer_core #(
  parameter int BUFFER_BYTES = lprx_pkg::BufferBytesDefault,
  parameter int DESCRIPTOR_DEPTH = lprx_pkg::DescriptorDepthDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [lprx_pkg::CommandWidth-1:0] command,
  input  logic [lprx_pkg::ReserveWidth-1:0] reserve_length,
  input  logic [lprx_pkg::AddressWidth-1:0] byte_address,
  input  logic [lprx_pkg::DataWidth-1:0]    write_data,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [lprx_pkg::StatusWidth-1:0]  status,
  output logic [lprx_pkg::IndexWidth-1:0]   start_index,
  output logic [lprx_pkg::LengthWidth-1:0]  packet_length,
  output logic [lprx_pkg::DataWidth-1:0]    read_data,
  output logic                              queue_empty
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int IW = $clog2(BUFFER_BYTES + 1);
  localparam int CW = ((IW > lprx_pkg::RawLengthWidth) ? IW : lprx_pkg::RawLengthWidth) + 1;
  localparam int PW = $clog2(DESCRIPTOR_DEPTH);
  localparam int NW = $clog2(DESCRIPTOR_DEPTH + 1);
  localparam int DW = IW + lprx_pkg::RawLengthWidth;

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_RD, S_RD_CAP, S_POP_RD, S_POP_CAP, S_RSV, S_CP_RD, S_CP_WR,
    S_RSV_FIT, S_RSV_HEAD, S_RSV_CHK, S_PR_TEST, S_PR_HI, S_PR_LO, S_DONE
  } state_t;

  state_t state;

  logic [CW-1:0] rlen;
  logic [AW-1:0] addr;
  logic [lprx_pkg::DataWidth-1:0] wdata;

  logic [IW-1:0] tail;
  logic [IW-1:0] unp;
  logic [IW-1:0] cp_idx;
  logic [PW-1:0] rptr;
  logic [PW-1:0] wptr;
  logic [NW-1:0] count;
  logic [lprx_pkg::DataWidth-1:0] hi_byte;

  logic [lprx_pkg::StatusWidth-1:0] st;
  logic [lprx_pkg::IndexWidth-1:0] res_start;
  logic [lprx_pkg::LengthWidth-1:0] res_len;
  logic [lprx_pkg::DataWidth-1:0] res_data;

  logic          bram_we;
  logic [AW-1:0] bram_waddr;
  logic [lprx_pkg::DataWidth-1:0] bram_wdata;
  logic [AW-1:0] bram_raddr;
  logic [lprx_pkg::DataWidth-1:0] bram_q;

  logic          dram_we;
  logic [DW-1:0] dram_wdata;
  logic [DW-1:0] dram_q;

  logic [CW-1:0] tail_c;
  logic [CW-1:0] unp_c;
  logic [CW-1:0] from_c;
  logic [CW-1:0] head_c;
  logic [CW-1:0] raw_c;
  logic [CW-1:0] room_c;
  logic          frame_fits;
  logic          queue_full;

  assign tail_c = CW'(tail);
  assign unp_c = CW'(unp);
  assign from_c = tail_c - unp_c;
  assign head_c = CW'(dram_q[DW-1:lprx_pkg::RawLengthWidth]);
  assign raw_c = CW'({hi_byte, bram_q});
  assign room_c = CW'(BUFFER_BYTES) - tail_c;
  assign frame_fits = (raw_c >= CW'(lprx_pkg::HeaderBytes)) && (raw_c <= unp_c);
  assign queue_full = (count >= NW'(DESCRIPTOR_DEPTH));

  assign item_stall = (state != S_IDLE);

  always_comb begin
    bram_we = 1'b0;
    bram_waddr = addr;
    bram_wdata = wdata;
    bram_raddr = addr;
    unique case (state)
      S_WR: begin
        bram_we = 1'b1;
      end
      S_CP_RD: begin
        bram_raddr = AW'(from_c + CW'(cp_idx));
      end
      S_CP_WR: begin
        bram_we = 1'b1;
        bram_waddr = AW'(cp_idx);
        bram_wdata = bram_q;
      end
      S_PR_TEST: begin
        bram_raddr = AW'(from_c);
      end
      S_PR_HI: begin
        bram_raddr = AW'(from_c + CW'(1));
      end
      default: begin
      end
    endcase
  end

  assign dram_we = (state == S_PR_LO) && frame_fits && !queue_full;
  assign dram_wdata = {IW'(from_c + CW'(lprx_pkg::HeaderBytes)),
                       lprx_pkg::RawLengthWidth'(raw_c - CW'(lprx_pkg::HeaderBytes))};

  lprx_ram #(
    .WIDTH(lprx_pkg::DataWidth),
    .DEPTH(BUFFER_BYTES)
  ) u_byte_store (
    .clk  (clk),
    .we   (bram_we),
    .waddr(bram_waddr),
    .wdata(bram_wdata),
    .raddr(bram_raddr),
    .rdata(bram_q)
  );

  lprx_ram #(
    .WIDTH(DW),
    .DEPTH(DESCRIPTOR_DEPTH)
  ) u_desc_queue (
    .clk  (clk),
    .we   (dram_we),
    .waddr(wptr),
    .wdata(dram_wdata),
    .raddr(rptr),
    .rdata(dram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tail <= '0;
      unp <= '0;
      rptr <= '0;
      wptr <= '0;
      count <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            rlen <= CW'(reserve_length);
            addr <= AW'(CW'(byte_address));
            wdata <= write_data;
            st <= lprx_pkg::ST_OK;
            res_start <= '0;
            res_len <= '0;
            res_data <= '0;
            unique case (command)
              lprx_pkg::CMD_RESERVE: state <= S_RSV;
              lprx_pkg::CMD_WRITE:   state <= S_WR;
              lprx_pkg::CMD_PROCESS: state <= S_PR_TEST;
              lprx_pkg::CMD_POP:     state <= S_POP_RD;
              lprx_pkg::CMD_READ:    state <= S_RD;
              default:               state <= S_DONE;
            endcase
          end
        end
        S_WR: begin
          state <= S_DONE;
        end
        S_RD: begin
          state <= S_RD_CAP;
        end
        S_RD_CAP: begin
          res_data <= bram_q;
          state <= S_DONE;
        end
        S_POP_RD: begin
          if (count == '0) begin
            st <= lprx_pkg::ST_EMPTY;
            state <= S_DONE;
          end else begin
            state <= S_POP_CAP;
          end
        end
        S_POP_CAP: begin
          res_start <= lprx_pkg::IndexWidth'(head_c);
          res_len <= lprx_pkg::LengthWidth'(dram_q[lprx_pkg::RawLengthWidth-1:0]);
          rptr <= (rptr == PW'(DESCRIPTOR_DEPTH - 1)) ? '0 : rptr + PW'(1);
          count <= count - NW'(1);
          state <= S_DONE;
        end
        S_RSV: begin
          if (rlen > room_c) begin
            if ((unp != '0) && (from_c != '0)) begin
              cp_idx <= '0;
              state <= S_CP_RD;
            end else begin
              tail <= unp;
              state <= S_RSV_FIT;
            end
          end else begin
            state <= S_RSV_HEAD;
          end
        end
        S_CP_RD: begin
          state <= S_CP_WR;
        end
        S_CP_WR: begin
          cp_idx <= cp_idx + IW'(1);
          if (cp_idx + IW'(1) == unp) begin
            tail <= unp;
            state <= S_RSV_FIT;
          end else begin
            state <= S_CP_RD;
          end
        end
        S_RSV_FIT: begin
          if (rlen > room_c) begin
            st <= lprx_pkg::ST_OVERFLOW;
            state <= S_DONE;
          end else begin
            state <= S_RSV_HEAD;
          end
        end
        S_RSV_HEAD: begin
          if (count == '0) begin
            res_start <= lprx_pkg::IndexWidth'(tail_c);
            unp <= IW'(unp_c + rlen);
            tail <= IW'(tail_c + rlen);
            state <= S_DONE;
          end else begin
            state <= S_RSV_CHK;
          end
        end
        S_RSV_CHK: begin
          if ((from_c <= head_c) && (tail_c + rlen > head_c)) begin
            st <= lprx_pkg::ST_OVERFLOW;
          end else begin
            res_start <= lprx_pkg::IndexWidth'(tail_c);
            unp <= IW'(unp_c + rlen);
            tail <= IW'(tail_c + rlen);
          end
          state <= S_DONE;
        end
        S_PR_TEST: begin
          if (unp_c < CW'(lprx_pkg::HeaderBytes)) begin
            state <= S_DONE;
          end else begin
            state <= S_PR_HI;
          end
        end
        S_PR_HI: begin
          hi_byte <= bram_q;
          state <= S_PR_LO;
        end
        S_PR_LO: begin
          if (!frame_fits) begin
            state <= S_DONE;
          end else if (queue_full) begin
            st <= lprx_pkg::ST_QFULL;
            state <= S_DONE;
          end else begin
            wptr <= (wptr == PW'(DESCRIPTOR_DEPTH - 1)) ? '0 : wptr + PW'(1);
            count <= count + NW'(1);
            unp <= IW'(unp_c - raw_c);
            state <= S_PR_TEST;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            status <= st;
            start_index <= res_start;
            packet_length <= res_len;
            read_data <= res_data;
            queue_empty <= (count == '0);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/lprx_checker.sv
module lprx_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_valid,
  input logic                              item_stall,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic [lprx_pkg::StatusWidth-1:0]  status,
  input logic [lprx_pkg::IndexWidth-1:0]   start_index,
  input logic [lprx_pkg::LengthWidth-1:0]  packet_length,
  input logic                              queue_empty
);

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("Result is pending right after reset.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) && $stable(start_index))
    else $error("Stalled result changed.");

  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("New transaction taken while a command is in progress.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == lprx_pkg::ST_EMPTY) |-> queue_empty && (packet_length == '0))
    else $error("Empty pop reports a packet.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == lprx_pkg::ST_OVERFLOW) |-> (start_index == '0))
    else $error("Overflow reports a reserved region.");

endmodule

bind length_prefixed_rx_frame_buffer_core lprx_checker u_lprx_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .start_index  (start_index),
  .packet_length(packet_length),
  .queue_empty  (queue_empty)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int StoreBytes = 8192;
  localparam int QueueDepth = 32;
  localparam int CycleLimit = 2000000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [lprx_pkg::StatusWidth-1:0] status;
    logic [lprx_pkg::IndexWidth-1:0]  start_index;
    logic [lprx_pkg::LengthWidth-1:0] packet_length;
    logic [lprx_pkg::DataWidth-1:0]   read_data;
    logic                             queue_empty;
  } outcome_t;

  class frame_buffer_scoreboard;
    bit [7:0] store [StoreBytes];
    bit       written [StoreBytes];
    int       tail;
    int       unparsed;
    int       desc_start [QueueDepth];
    int       desc_len [QueueDepth];
    int       rd_ptr;
    int       wr_ptr;
    int       queued;
    int       items;
    int       mismatches;
    bit       broken;
    outcome_t last;
    outcome_t outcomes [$];

    function logic [lprx_pkg::StatusWidth-1:0] reserve(int len, output int start);
      int from;
      int head;
      start = 0;
      if (len > StoreBytes - tail) begin
        from = tail - unparsed;
        for (int i = 0; i < unparsed; i++) begin
          store[i] = store[from + i];
          written[i] = written[from + i];
        end
        tail = unparsed;
        if (len > StoreBytes - tail) return lprx_pkg::ST_OVERFLOW;
      end
      if (queued != 0) begin
        head = desc_start[rd_ptr];
        if (tail - unparsed <= head && tail + len > head) return lprx_pkg::ST_OVERFLOW;
      end
      start = tail;
      unparsed += len;
      tail += len;
      return lprx_pkg::ST_OK;
    endfunction

    function logic [lprx_pkg::StatusWidth-1:0] parse_frames();
      int at;
      int raw;
      while (unparsed >= lprx_pkg::HeaderBytes) begin
        at = tail - unparsed;
        raw = {store[at % StoreBytes], store[(at + 1) % StoreBytes]};
        if (raw < lprx_pkg::HeaderBytes || raw > unparsed) return lprx_pkg::ST_OK;
        if (queued >= QueueDepth) return lprx_pkg::ST_QFULL;
        desc_start[wr_ptr] = at + lprx_pkg::HeaderBytes;
        desc_len[wr_ptr] = raw - lprx_pkg::HeaderBytes;
        wr_ptr = (wr_ptr + 1) % QueueDepth;
        queued++;
        unparsed -= raw;
      end
      return lprx_pkg::ST_OK;
    endfunction

    function void note_item(logic [2:0] cmd, int len, int addr, logic [7:0] data);
      outcome_t r;
      int start;
      r = '0;
      start = 0;
      case (cmd)
        lprx_pkg::CMD_RESERVE: begin
          r.status = reserve(len, start);
          r.start_index = start[lprx_pkg::IndexWidth-1:0];
        end
        lprx_pkg::CMD_WRITE: begin
          store[addr] = data;
          written[addr] = 1'b1;
        end
        lprx_pkg::CMD_PROCESS: r.status = parse_frames();
        lprx_pkg::CMD_POP: begin
          if (queued == 0) begin
            r.status = lprx_pkg::ST_EMPTY;
          end else begin
            r.start_index = desc_start[rd_ptr][lprx_pkg::IndexWidth-1:0];
            r.packet_length = desc_len[rd_ptr][lprx_pkg::LengthWidth-1:0];
            rd_ptr = (rd_ptr + 1) % QueueDepth;
            queued--;
          end
        end
        lprx_pkg::CMD_READ: r.read_data = store[addr];
        default: ;
      endcase
      r.queue_empty = (queued == 0);
      last = r;
      items++;
      outcomes.push_back(r);
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (outcomes.size() == 0) begin
        broken = 1'b1;
        $display("unexpected result transaction: %p", got);
        return;
      end
      want = outcomes.pop_front();
      if (got !== want) begin
        broken = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              item_valid = 1'b0;
  logic                              item_stall;
  logic [lprx_pkg::CommandWidth-1:0] command = lprx_pkg::CMD_RESERVE;
  logic [lprx_pkg::ReserveWidth-1:0] reserve_length = '0;
  logic [lprx_pkg::AddressWidth-1:0] byte_address = '0;
  logic [lprx_pkg::DataWidth-1:0]    write_data = '0;
  logic                              result_valid;
  logic                              result_stall = 1'b0;
  logic [lprx_pkg::StatusWidth-1:0]  status;
  logic [lprx_pkg::IndexWidth-1:0]   start_index;
  logic [lprx_pkg::LengthWidth-1:0]  packet_length;
  logic [lprx_pkg::DataWidth-1:0]    read_data;
  logic                              queue_empty;

  frame_buffer_scoreboard sb = new();
  int  idle_pct = 35;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  cycles = 0;

  length_prefixed_rx_frame_buffer_core u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .command(command), .reserve_length(reserve_length),
    .byte_address(byte_address), .write_data(write_data),
    .result_valid(result_valid), .result_stall(result_stall),
    .status(status), .start_index(start_index), .packet_length(packet_length),
    .read_data(read_data), .queue_empty(queue_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("length_prefixed_rx_frame_buffer_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result({status, start_index, packet_length, read_data, queue_empty});
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HoldCycles;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic send(logic [2:0] cmd, int len, int addr, int data);
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_valid <= 1'b1;
    command <= cmd;
    reserve_length <= len[lprx_pkg::ReserveWidth-1:0];
    byte_address <= addr[lprx_pkg::AddressWidth-1:0];
    write_data <= data[lprx_pkg::DataWidth-1:0];
    do @(posedge clk); while (item_stall);
    sb.note_item(cmd, len, addr, data[7:0]);
  endtask

  // This task writes every byte that it reserves before it sends a process command,
  // so the block never parses a byte that was never written.
  task automatic send_frames(int count, bit corrupt, int pops);
    int lens [$];
    int total;
    int start;
    int raw;
    int at;
    total = 0;
    for (int i = 0; i < count; i++) begin
      lens.push_back(($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(12));
      total += lens[i] + lprx_pkg::HeaderBytes;
    end
    send(lprx_pkg::CMD_RESERVE, total, $urandom_range(StoreBytes - 1), $urandom_range(255));
    if (sb.last.status == lprx_pkg::ST_OK) begin
      start = sb.last.start_index;
      at = start;
      foreach (lens[i]) begin
        raw = lens[i] + lprx_pkg::HeaderBytes;
        if (corrupt && $urandom_range(1) == 0)
          raw = ($urandom_range(1) == 0) ? $urandom_range(1) : $urandom_range(65535);
        send(lprx_pkg::CMD_WRITE, 0, at, raw >> 8);
        send(lprx_pkg::CMD_WRITE, 0, at + 1, raw & 8'hff);
        for (int j = 0; j < lens[i]; j++)
          send(lprx_pkg::CMD_WRITE, 0, at + lprx_pkg::HeaderBytes + j, $urandom_range(255));
        at += lens[i] + lprx_pkg::HeaderBytes;
      end
      send(lprx_pkg::CMD_READ, 0, start + $urandom_range(total - 1), 0);
    end
    send(lprx_pkg::CMD_PROCESS, 0, 0, 0);
    repeat (pops) send(lprx_pkg::CMD_POP, 0, 0, 0);
  endtask

  task automatic repair_chunk();
    int at;
    if (sb.unparsed >= lprx_pkg::HeaderBytes) begin
      at = sb.tail - sb.unparsed;
      send(lprx_pkg::CMD_WRITE, 0, at, sb.unparsed >> 8);
      send(lprx_pkg::CMD_WRITE, 0, at + 1, sb.unparsed & 8'hff);
      send(lprx_pkg::CMD_PROCESS, 0, 0, 0);
    end
  endtask

  task automatic send_noise();
    int addr;
    case ($urandom_range(4))
      0: send(lprx_pkg::CMD_WRITE, 0, $urandom_range(StoreBytes - 1), $urandom_range(255));
      1: begin
        addr = $urandom_range(StoreBytes - 1);
        if (sb.written[addr]) send(lprx_pkg::CMD_READ, 0, addr, $urandom_range(255));
      end
      2: send(3'(lprx_pkg::CMD_READ + $urandom_range(1, 3)), $urandom_range(16383),
              $urandom_range(StoreBytes - 1), $urandom_range(255));
      3: send(lprx_pkg::CMD_POP, 0, 0, 0);
      default: begin
        send(lprx_pkg::CMD_RESERVE, $urandom_range(StoreBytes / 2, StoreBytes), 0, 0);
        repair_chunk();
      end
    endcase
  endtask

  initial begin
    int round;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(lprx_pkg::CMD_POP, 0, 0, 0);
    send(lprx_pkg::CMD_PROCESS, 0, 0, 0);
    send(3'(lprx_pkg::CMD_READ + 1), 0, 0, 0);
    send(3'(lprx_pkg::CMD_READ + 2), 0, 0, 0);
    send(3'(lprx_pkg::CMD_READ + 3), 16383, StoreBytes - 1, 255);
    send(lprx_pkg::CMD_WRITE, 0, StoreBytes - 1, 255);
    send(lprx_pkg::CMD_WRITE, 0, 0, 0);
    send(lprx_pkg::CMD_READ, 0, StoreBytes - 1, 0);
    send(lprx_pkg::CMD_READ, 0, 0, 0);
    send(lprx_pkg::CMD_RESERVE, 0, 0, 0);
    send(lprx_pkg::CMD_RESERVE, 1, 0, 0);
    send(lprx_pkg::CMD_WRITE, 0, 0, 0);
    send(lprx_pkg::CMD_PROCESS, 0, 0, 0);
    send_frames(1, 0, 1);
    send_frames(2, 1, 2);
    repair_chunk();
    send(lprx_pkg::CMD_POP, 0, 0, 0);

    round = 0;
    while (sb.items < 400) begin
      idle_pct = (round >= 30 && round < 50) ? 0 : 35;
      if (round == 60) hold_req <= 1'b1;
      if ($urandom_range(4) == 0) send_noise();
      else send_frames($urandom_range(1, 4), $urandom_range(9) == 0,
                       (round % 40 < 15) ? 0 : $urandom_range(5));
      if (sb.unparsed >= lprx_pkg::HeaderBytes && $urandom_range(2) == 0) repair_chunk();
      round++;
    end

    idle_pct = 35;
    while (sb.queued > 0) send(lprx_pkg::CMD_POP, 0, 0, 0);
    repair_chunk();
    while (sb.queued > 0) send(lprx_pkg::CMD_POP, 0, 0, 0);
    send(lprx_pkg::CMD_RESERVE, StoreBytes, 0, 0);
    send(lprx_pkg::CMD_RESERVE, 0, 0, 0);
    send(lprx_pkg::CMD_RESERVE, 1, 0, 0);
    send(lprx_pkg::CMD_POP, 0, 0, 0);
    item_valid <= 1'b0;

    while (sb.outcomes.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (!sb.broken) begin
      $display("length_prefixed_rx_frame_buffer_core regression: pass");
    end else begin
      $display("length_prefixed_rx_frame_buffer_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: length_prefixed_rx_frame_buffer_core.f
rtl/lprx_pkg.sv
rtl/lprx_ram.sv
rtl/length_prefixed_rx_frame_buffer_core.sv
rtl/lprx_checker.sv
tb/testbench.sv
